[rtl/core/ptt_pkg.sv]
package ptt_pkg;

    // command codes
    localparam logic [2:0] OP_CREATE  = 3'd0;
    localparam logic [2:0] OP_MODIFY  = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_START   = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_TICK    = 3'd5;

    // status codes
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam int ID_W  = 8;
    localparam int EID_W = 7;
    localparam int PER_W = 32;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [ID_W-1:0]  timer_id;
        logic [PER_W-1:0] period_ticks;
    } cmd_t;

    typedef struct packed {
        logic             is_expiry;
        logic             status;
        logic [EID_W-1:0] expired_id;
        logic             last;
    } rpt_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMD,
        S_TICK
    } state_t;

endpackage

[rtl/core/periodic_timer_table.sv]
// channel | direction | handshake            | word
// --------+-----------+----------------------+------------------------------------
// cmd     | in        | cmd_valid / cmd_stall | opcode, timer_id, period_ticks
// rpt     | out       | rpt_valid / rpt_stall | is_expiry, status, expired_id, last
//
// a command word is captured, then the table is updated and the status word sent
// a tick walks the C created timers: the single read port of the count/period memories
// visits one slot per cycle while the walk is not held, read then write back
// reset clears the created count, running flags and count valid bits at once;
// no clearing pass, a count entry never written reads as zero
// rpt_stall holds the walk when a second expiry is found, or the last one is
// ready to go out, while the report register is still full; a command status
// waits for a free report register the same way; cmd_stall is high while a
// word is in work
module periodic_timer_table #(
    parameter int NUM_TIMERS = 16,
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ptt_pkg::cmd_t     cmd,
    output logic              rpt_valid,
    input  logic              rpt_stall,
    output ptt_pkg::rpt_t     rpt
);

    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);

    // state machine and control
    ptt_pkg::state_t               state_reg, state_next;
    ptt_pkg::cmd_t                 cmd_reg;
    logic [CNT_W-1:0]              created_cnt_reg, created_cnt_next;
    logic [NUM_TIMERS-1:0]         running_reg, running_next;
    logic [NUM_TIMERS-1:0]         cnt_vld_reg, cnt_vld_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic                          b_valid_reg, b_valid_next;
    logic [SLOT_W-1:0]             b_slot_reg, b_slot_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [ptt_pkg::EID_W-1:0]     pend_id_reg, pend_id_next;
    logic                          rpt_valid_reg, rpt_valid_next;
    ptt_pkg::rpt_t                 rpt_reg, rpt_next;

    // memories: count and period per slot
    logic [TIME_WIDTH-1:0]         count_mem  [NUM_TIMERS];
    logic [TIME_WIDTH-1:0]         period_mem [NUM_TIMERS];
    logic [TIME_WIDTH-1:0]         rd_cnt_reg;
    logic [TIME_WIDTH-1:0]         rd_per_reg;
    logic                          rd_vld_reg;

    logic                          rd_en;
    logic [SLOT_W-1:0]             rd_addr;
    logic                          cw_en;
    logic [SLOT_W-1:0]             cw_addr;
    logic [TIME_WIDTH-1:0]         cw_data;
    logic                          pw_en;
    logic [SLOT_W-1:0]             pw_addr;
    logic [TIME_WIDTH-1:0]         pw_data;

    // command decode
    logic [ptt_pkg::ID_W-1:0]      id_m1;
    logic [SLOT_W-1:0]             cmd_slot;
    logic                          bad_id;
    logic                          fail;

    // tick datapath
    logic [TIME_WIDTH-1:0]         cnt_cur;
    logic [TIME_WIDTH-1:0]         cnt_inc;
    logic                          b_run;
    logic                          b_exp;
    logic [ptt_pkg::EID_W-1:0]     slot_id;
    logic                          rpt_free;
    logic                          b_block;

    assign cmd_stall = (state_reg != ptt_pkg::S_IDLE);
    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

    assign rpt_free = !rpt_valid_reg || !rpt_stall;

    assign id_m1    = cmd_reg.timer_id - ptt_pkg::ID_W'(1);
    assign cmd_slot = id_m1[SLOT_W-1:0];
    assign bad_id   = (cmd_reg.timer_id == '0) ||
                      (cmd_reg.timer_id > ptt_pkg::ID_W'(NUM_TIMERS));

    // the slot being processed: an entry never written counts from zero
    assign cnt_cur = rd_vld_reg ? rd_cnt_reg : '0;
    assign cnt_inc = cnt_cur + TIME_WIDTH'(1);
    assign b_run   = running_reg[b_slot_reg];
    assign b_exp   = b_run && (cnt_inc == rd_per_reg);
    assign slot_id = ptt_pkg::EID_W'(b_slot_reg) + ptt_pkg::EID_W'(1);

    // a second expiry needs the report register while the first is held back
    assign b_block = b_valid_reg && b_exp && pend_valid_reg && !rpt_free;

    always_comb
    begin
        state_next       = state_reg;
        created_cnt_next = created_cnt_reg;
        running_next     = running_reg;
        cnt_vld_next     = cnt_vld_reg;
        idx_next         = idx_reg;
        b_valid_next     = b_valid_reg;
        b_slot_next      = b_slot_reg;
        pend_valid_next  = pend_valid_reg;
        pend_id_next     = pend_id_reg;
        rpt_valid_next   = rpt_valid_reg && rpt_stall;
        rpt_next         = rpt_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[SLOT_W-1:0];
        cw_en            = 1'b0;
        cw_addr          = cmd_slot;
        cw_data          = '0;
        pw_en            = 1'b0;
        pw_addr          = cmd_slot;
        pw_data          = cmd_reg.period_ticks[TIME_WIDTH-1:0];
        fail             = 1'b0;

        case (state_reg)
            ptt_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.opcode == ptt_pkg::OP_TICK)
                    begin
                        state_next      = ptt_pkg::S_TICK;
                        idx_next        = '0;
                        b_valid_next    = 1'b0;
                        pend_valid_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ptt_pkg::S_CMD;
                    end
                end
            end

            ptt_pkg::S_CMD:
            begin
                if (rpt_free)
                begin
                    fail = bad_id;
                    if (!bad_id)
                    begin
                        case (cmd_reg.opcode)
                            ptt_pkg::OP_CREATE:
                            begin
                                // created slots form a prefix, so the count says it all
                                if (id_m1 > ptt_pkg::ID_W'(created_cnt_reg))
                                begin
                                    fail = 1'b1;
                                end
                                else
                                begin
                                    pw_en = 1'b1;
                                    if (id_m1 == ptt_pkg::ID_W'(created_cnt_reg))
                                    begin
                                        created_cnt_next = created_cnt_reg + CNT_W'(1);
                                    end
                                end
                            end
                            ptt_pkg::OP_MODIFY:
                            begin
                                pw_en                  = 1'b1;
                                cw_en                  = 1'b1;
                                cnt_vld_next[cmd_slot] = 1'b1;
                            end
                            ptt_pkg::OP_RESTART:
                            begin
                                cw_en                  = 1'b1;
                                cnt_vld_next[cmd_slot] = 1'b1;
                                running_next[cmd_slot] = 1'b1;
                            end
                            ptt_pkg::OP_START:
                            begin
                                running_next[cmd_slot] = 1'b1;
                            end
                            ptt_pkg::OP_STOP:
                            begin
                                cw_en                  = 1'b1;
                                cnt_vld_next[cmd_slot] = 1'b1;
                                running_next[cmd_slot] = 1'b0;
                            end
                            default:
                            begin
                                fail = 1'b1;
                            end
                        endcase
                    end
                    rpt_valid_next      = 1'b1;
                    rpt_next.is_expiry  = 1'b0;
                    rpt_next.status     = fail ? ptt_pkg::ST_FAIL : ptt_pkg::ST_OK;
                    rpt_next.expired_id = '0;
                    rpt_next.last       = 1'b1;
                    state_next          = ptt_pkg::S_IDLE;
                end
            end

            ptt_pkg::S_TICK:
            begin
                if (!b_block)
                begin
                    // write back the slot whose read is held in the read registers
                    if (b_valid_reg && b_run)
                    begin
                        cw_en                    = 1'b1;
                        cw_addr                  = b_slot_reg;
                        cw_data                  = b_exp ? '0 : cnt_inc;
                        cnt_vld_next[b_slot_reg] = 1'b1;
                    end
                    // an expiry is held back until the next one shows it was not last
                    if (b_valid_reg && b_exp)
                    begin
                        if (pend_valid_reg)
                        begin
                            rpt_valid_next      = 1'b1;
                            rpt_next.is_expiry  = 1'b1;
                            rpt_next.status     = ptt_pkg::ST_OK;
                            rpt_next.expired_id = pend_id_reg;
                            rpt_next.last       = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = slot_id;
                    end
                    // issue the read of the next created slot
                    if (idx_reg != created_cnt_reg)
                    begin
                        rd_en        = 1'b1;
                        idx_next     = idx_reg + CNT_W'(1);
                        b_valid_next = 1'b1;
                        b_slot_next  = idx_reg[SLOT_W-1:0];
                    end
                    else
                    begin
                        b_valid_next = 1'b0;
                        // walk done and pipe empty: flush the held expiry as last
                        if (!b_valid_reg)
                        begin
                            if (!pend_valid_reg)
                            begin
                                state_next = ptt_pkg::S_IDLE;
                            end
                            else if (rpt_free)
                            begin
                                rpt_valid_next      = 1'b1;
                                rpt_next.is_expiry  = 1'b1;
                                rpt_next.status     = ptt_pkg::ST_OK;
                                rpt_next.expired_id = pend_id_reg;
                                rpt_next.last       = 1'b1;
                                pend_valid_next     = 1'b0;
                                state_next          = ptt_pkg::S_IDLE;
                            end
                        end
                    end
                end
            end

            default:
            begin
                state_next = ptt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ptt_pkg::S_IDLE;
            created_cnt_reg <= '0;
            running_reg     <= '0;
            cnt_vld_reg     <= '0;
            idx_reg         <= '0;
            b_valid_reg     <= 1'b0;
            pend_valid_reg  <= 1'b0;
            rpt_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            created_cnt_reg <= created_cnt_next;
            running_reg     <= running_next;
            cnt_vld_reg     <= cnt_vld_next;
            idx_reg         <= idx_next;
            b_valid_reg     <= b_valid_next;
            pend_valid_reg  <= pend_valid_next;
            rpt_valid_reg   <= rpt_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
        b_slot_reg  <= b_slot_next;
        pend_id_reg <= pend_id_next;
        rpt_reg     <= rpt_next;
    end

    // count memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            count_mem[cw_addr] <= cw_data;
        end
        if (rd_en)
        begin
            rd_cnt_reg <= count_mem[rd_addr];
            rd_vld_reg <= cnt_vld_reg[rd_addr];
        end
    end

    // period memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            period_mem[pw_addr] <= pw_data;
        end
        if (rd_en)
        begin
            rd_per_reg <= period_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    // a held expiry never outlives its tick
    a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ptt_pkg::S_TICK) |-> !pend_valid_reg)
        else $error("held expiry outside tick");

    // the read pipe is empty outside a tick
    a_pipe_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (state_reg == ptt_pkg::S_TICK))
        else $error("slot in flight outside tick");

    // the walk never passes the created prefix
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptt_pkg::S_TICK) |-> (idx_reg <= created_cnt_reg))
        else $error("tick walk beyond created timers");

    // a command leaves a status word in the report register
    a_cmd_status: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ptt_pkg::S_CMD) && rpt_free) |=> (rpt_valid_reg && !rpt_reg.is_expiry
        && rpt_reg.last))
        else $error("missing command status");
`endif

endmodule

[bench/periodic_timer_table_tb.sv]
module periodic_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // block configuration under test
    localparam int NT = 16;
    localparam int TW = 32;

    localparam int CLK_PERIOD   = 20;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_WORDS = 210;
    // margin for a tick walk over all slots, plus room for stalls
    localparam int DRAIN_CYCLES = 4 * NT;

    // opcodes the block does not define, both must be refused
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    // how a stimulus row gets its expected words
    localparam int FROM_MODEL = -1;

    localparam ptt_pkg::rpt_t RPT_OK   = '{is_expiry: 1'b0, status: ptt_pkg::ST_OK,
                                           expired_id: '0, last: 1'b1};
    localparam ptt_pkg::rpt_t RPT_FAIL = '{is_expiry: 1'b0, status: ptt_pkg::ST_FAIL,
                                           expired_id: '0, last: 1'b1};

    typedef struct {
        ptt_pkg::cmd_t w;
        int            n_typed;
        ptt_pkg::rpt_t typed;
    } row_t;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_stall;
    ptt_pkg::cmd_t cmd       = '0;
    logic          rpt_valid;
    logic          rpt_stall = 1'b0;
    ptt_pkg::rpt_t rpt;

    // no idling on either side while this is set
    logic calm = 1'b0;

    int            mismatches = 0;
    int            cycles     = 0;
    ptt_pkg::rpt_t want;

    // shadow copy of the timer table
    bit          slot_made    [NT];
    bit          slot_running [NT];
    bit [TW-1:0] slot_count   [NT];
    bit [TW-1:0] slot_period  [NT];

    // words produced by the latest command, and all words still owed by the block
    ptt_pkg::rpt_t step_words[$];
    ptt_pkg::rpt_t pending_reports[$];

    // directed rows: refusals and plain successes are typed in, ticks come from the shadow
    row_t plan [0:24] = '{
        // nothing created yet, so a tick reports nothing
        '{'{ptt_pkg::OP_TICK,    8'd0,   32'd0},          0, RPT_OK},
        // bad ids, both extremes of the id field
        '{'{ptt_pkg::OP_CREATE,  8'd0,   32'd5},          1, RPT_FAIL},
        '{'{ptt_pkg::OP_CREATE,  8'd17,  32'd5},          1, RPT_FAIL},
        '{'{ptt_pkg::OP_CREATE,  8'd255, 32'hFFFF_FFFF},  1, RPT_FAIL},
        // create with a gap below it
        '{'{ptt_pkg::OP_CREATE,  8'd2,   32'd3},          1, RPT_FAIL},
        // undefined opcodes
        '{'{OP_RSVD6,            8'd1,   32'd1},          1, RPT_FAIL},
        '{'{OP_RSVD7,            8'd1,   32'd1},          1, RPT_FAIL},
        // start on a slot that does not exist yet still succeeds
        '{'{ptt_pkg::OP_START,   8'd3,   32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_CREATE,  8'd1,   32'd1},          1, RPT_OK},
        '{'{ptt_pkg::OP_CREATE,  8'd2,   32'hFFFF_FFFF},  1, RPT_OK},
        '{'{ptt_pkg::OP_CREATE,  8'd3,   32'd2},          1, RPT_OK},
        '{'{ptt_pkg::OP_START,   8'd1,   32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_TICK,    8'd0,   32'd0},          FROM_MODEL, RPT_OK},
        // tick ignores its id and period fields
        '{'{ptt_pkg::OP_TICK,    8'd255, 32'hFFFF_FFFF},  FROM_MODEL, RPT_OK},
        // zero period only fires on wrap
        '{'{ptt_pkg::OP_MODIFY,  8'd3,   32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_RESTART, 8'd2,   32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_STOP,    8'd1,   32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_TICK,    8'd0,   32'd0},          FROM_MODEL, RPT_OK},
        // create of an existing timer only reloads its period
        '{'{ptt_pkg::OP_CREATE,  8'd1,   32'd3},          1, RPT_OK},
        '{'{ptt_pkg::OP_MODIFY,  8'd0,   32'd7},          1, RPT_FAIL},
        '{'{ptt_pkg::OP_RESTART, 8'd16,  32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_STOP,    8'd255, 32'd0},          1, RPT_FAIL},
        '{'{ptt_pkg::OP_CREATE,  8'd4,   32'd1},          1, RPT_OK},
        '{'{ptt_pkg::OP_START,   8'd4,   32'd0},          1, RPT_OK},
        '{'{ptt_pkg::OP_TICK,    8'hAA,  32'h5555_AAAA},  FROM_MODEL, RPT_OK}
    };

    periodic_timer_table #(
        .NUM_TIMERS (NT),
        .TIME_WIDTH (TW)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still owed",
                     cycles, pending_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [6:0] got,
                               input logic [6:0] exp_val);
        if (got !== exp_val)
            flag_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
    endtask

    // shadow of the timer table: apply one command word, collect the words it causes
    function automatic void step_timer_table(input ptt_pkg::cmd_t w);
        int            s;
        int            j;
        bit            fail;
        ptt_pkg::rpt_t r;
        step_words.delete();
        if (w.opcode == ptt_pkg::OP_TICK)
        begin
            // walk upward, stop at the first slot never created
            for (s = 0; s < NT; s++)
            begin
                if (!slot_made[s])
                    break;
                if (slot_running[s])
                begin
                    slot_count[s] = slot_count[s] + 1'b1;
                    if (slot_count[s] == slot_period[s])
                    begin
                        slot_count[s] = '0;
                        r = '{is_expiry: 1'b1, status: ptt_pkg::ST_OK,
                              expired_id: ptt_pkg::EID_W'(s + 1), last: 1'b0};
                        step_words.push_back(r);
                    end
                end
            end
            // mark the final expiry of this tick
            if (step_words.size() != 0)
            begin
                r = step_words.pop_back();
                r.last = 1'b1;
                step_words.push_back(r);
            end
            return;
        end
        fail = (w.opcode > ptt_pkg::OP_TICK) || (w.timer_id == 0) || (w.timer_id > NT);
        if (!fail)
        begin
            s = w.timer_id - 1;
            case (w.opcode)
                ptt_pkg::OP_CREATE:
                begin
                    for (j = 0; j < s; j++)
                        if (!slot_made[j])
                            fail = 1'b1;
                    if (!fail)
                    begin
                        slot_made[s]   = 1'b1;
                        slot_period[s] = w.period_ticks[TW-1:0];
                    end
                end
                ptt_pkg::OP_MODIFY:
                begin
                    slot_count[s]  = '0;
                    slot_period[s] = w.period_ticks[TW-1:0];
                end
                ptt_pkg::OP_RESTART:
                begin
                    slot_count[s]   = '0;
                    slot_running[s] = 1'b1;
                end
                ptt_pkg::OP_START:
                    slot_running[s] = 1'b1;
                default:
                begin
                    slot_running[s] = 1'b0;
                    slot_count[s]   = '0;
                end
            endcase
        end
        step_words.push_back(fail ? RPT_FAIL : RPT_OK);
    endfunction

    // random command word, biased so the table fills and timers fire often
    function automatic ptt_pkg::cmd_t pick_word();
        ptt_pkg::cmd_t w;
        int            chain;
        int            r;
        chain = 0;
        while (chain < NT && slot_made[chain])
            chain++;
        w.period_ticks = $urandom_range(1, 4);
        r = $urandom_range(0, 99);
        if (r < 15)
            w.period_ticks = $urandom;
        else if (r < 25)
            w.period_ticks = $urandom_range(0, 12);
        w.timer_id = ptt_pkg::ID_W'($urandom_range(1, NT));
        if ($urandom_range(0, 99) < 15)
            w.timer_id = ptt_pkg::ID_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            w.opcode       = ptt_pkg::OP_TICK;
            w.timer_id     = ptt_pkg::ID_W'($urandom_range(0, 255));
            w.period_ticks = $urandom;
        end
        else if (r < 50)
        begin
            w.opcode = ptt_pkg::OP_CREATE;
            // mostly the next free id or a re-create, sometimes a gap
            if ($urandom_range(0, 99) < 80)
                w.timer_id = ptt_pkg::ID_W'($urandom_range(1, (chain < NT) ? chain + 1 : NT));
            else
                w.timer_id = ptt_pkg::ID_W'($urandom_range(0, 255));
        end
        else if (r < 58)
            w.opcode = ptt_pkg::OP_MODIFY;
        else if (r < 72)
            w.opcode = ptt_pkg::OP_RESTART;
        else if (r < 84)
            w.opcode = ptt_pkg::OP_START;
        else if (r < 97)
            w.opcode = ptt_pkg::OP_STOP;
        else
            w.opcode = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        return w;
    endfunction

    // hand one word to the block; valid stays high into the next word unless a gap is drawn
    task automatic send_word(input ptt_pkg::cmd_t w, input int n_typed,
                             input ptt_pkg::rpt_t typed);
        int k;
        if (!calm && $urandom_range(0, 99) < 7)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < 40)
                @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // accepted at this edge: update the shadow and queue what is owed
        step_timer_table(w);
        if (n_typed == FROM_MODEL)
        begin
            for (k = 0; k < step_words.size(); k++)
                pending_reports.push_back(step_words[k]);
        end
        else if (n_typed == 1)
            pending_reports.push_back(typed);
    endtask

    // report side: check each accepted word, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rpt_valid && !rpt_stall)
            begin
                if (pending_reports.size() == 0)
                    flag_mismatch($sformatf("word with nothing owed: %p", rpt));
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("is_expiry", 7'(rpt.is_expiry), 7'(want.is_expiry));
                    check_field("status", 7'(rpt.status), 7'(want.status));
                    check_field("expired_id", rpt.expired_id, want.expired_id);
                    check_field("last", 7'(rpt.last), 7'(want.last));
                end
            end
            rpt_stall <= !calm && ($urandom_range(0, 99) < 7);
        end
    end

    initial
    begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (i = 0; i < $size(plan); i++)
            send_word(plan[i].w, plan[i].n_typed, plan[i].typed);

        // random words, with a quiet stretch in the middle
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            calm <= (i >= 90) && (i < 150);
            send_word(pick_word(), FROM_MODEL, RPT_OK);
        end

        cmd_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        // a tick that fires nothing may still be walking the table
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
            flag_mismatch($sformatf("%0d words never arrived", pending_reports.size()));

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
